// ===== rtl/core/lrip_pkg.sv =====
// ============================================================================
// lrip_pkg - shared types and constants of the range image projector
// Register codes, reset values, default sizes and the controller/datapath
// command and status bundles.
// ============================================================================
package lrip_pkg;

    // Default store sizes
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_POINTS = 131072;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOV_DOWN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOV_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_RANGE_LIMIT = 16'd65535;
    localparam logic [14:0] RST_FOV_DOWN    = 15'd4551;
    localparam logic [31:0] RST_FOV_SCALE   = 32'd524288;
    localparam logic [6:0]  RST_IMAGE_ROWS  = 7'd64;
    localparam logic [10:0] RST_IMAGE_COLS  = 11'd1024;

    // Stream word widths
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;

    // Operation codes carried in the input tuser
    localparam logic OP_PROJECT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic sweep;     // clear one valid mark of the reset sweep
        logic take_in;   // capture the input word
        logic mul1;      // column and field-of-view products
        logic mul2;      // row product, column result
        logic addr;      // final row/col and pixel address
        logic mem;       // store write or store read
        logic clear_wr;  // clear valid mark after read
        logic load_out;  // load the result word
    } lrip_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;  // last entry of the reset sweep
        logic is_read;     // current item is a read request
    } lrip_stat_t;

endpackage

// ===== rtl/core/lrip_ctrl.sv =====
// ============================================================================
// lrip_ctrl - sequencer of the range image projector
// Steps one item through the multiply, address and store phases, runs the
// valid mark sweep after reset and holds the result handshake.
// ============================================================================
module lrip_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lrip_pkg::lrip_cmd_t cmd,
    input  lrip_pkg::lrip_stat_t stat
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ADDR,
        S_MEM,
        S_RDWAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands from the state
    always_comb
    begin
        cmd          = '0;
        cmd.sweep    = (state_reg == S_SWEEP);
        cmd.take_in  = (state_reg == S_IDLE) && in_valid;
        cmd.mul1     = (state_reg == S_MUL1);
        cmd.mul2     = (state_reg == S_MUL2);
        cmd.addr     = (state_reg == S_ADDR);
        cmd.mem      = (state_reg == S_MEM);
        cmd.clear_wr = (state_reg == S_RDWAIT);
        cmd.load_out = (state_reg == S_FINISH) && out_free;
    end

    // Next state and result valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_ADDR;
            S_ADDR:   state_next = S_MEM;
            S_MEM:    state_next = stat.is_read ? S_RDWAIT : S_FINISH;
            S_RDWAIT: state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending word");

    // A read request goes through the read wait phase
    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEM) && stat.is_read |=> (state_reg == S_RDWAIT))
        else $error("read request skipped the read wait phase");

    // An accepted word reaches the end of its store phase
    a_item_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##5 ((state_reg == S_FINISH) || (state_reg == S_RDWAIT)))
        else $error("accepted word did not reach the store phase in time");

    // The reset sweep ends only at its last entry
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) && !stat.sweep_last |=> (state_reg == S_SWEEP))
        else $error("valid sweep left early");
`endif

endmodule

// ===== rtl/core/lrip_dpath.sv =====
// ============================================================================
// lrip_dpath - datapath of the range image projector
// Configuration registers, column/row fixed-point arithmetic, pixel stores
// with valid marks, and the result register.
// ============================================================================
module lrip_dpath
#(
    parameter int MAX_ROWS   = lrip_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = lrip_pkg::DEF_MAX_COLS,
    parameter int MAX_POINTS = lrip_pkg::DEF_MAX_POINTS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [lrip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic [lrip_pkg::IN_DATA_W-1:0]    in_data,
    input  logic                              in_op,
    output logic [lrip_pkg::OUT_DATA_W-1:0]   out_data,
    input  lrip_pkg::lrip_cmd_t               cmd,
    output lrip_pkg::lrip_stat_t              stat
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int PIXELS = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(PIXELS);

    // Configuration registers
    logic [15:0] range_limit_reg;
    logic [14:0] fov_down_reg;
    logic [31:0] fov_scale_reg;
    logic [6:0]  image_rows_reg;
    logic [10:0] image_cols_reg;

    // Captured input word
    logic        op_reg;
    logic [15:0] rho_reg;
    logic [15:0] az_reg;
    logic [15:0] polar_reg;
    logic [16:0] pnum_reg;
    logic [5:0]  rrow_reg;
    logic [9:0]  rcol_reg;
    logic        clr_reg;

    // Arithmetic stages
    logic [COL_W+15:0] col_prod_reg;
    logic [47:0]       nprod_reg;
    logic              npos_reg;
    logic              skip_reg;
    logic [ROW_W+16:0] row_prod_reg;
    logic [COL_W-1:0]  col_calc_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;

    // Stores
    logic [15:0] range_mem [PIXELS];
    logic [16:0] index_mem [PIXELS];
    logic        valid_mem [PIXELS];
    logic [15:0] rd_range_reg;
    logic [16:0] rd_index_reg;
    logic        rd_valid_reg;

    // Result register
    logic [lrip_pkg::OUT_DATA_W-1:0] out_word_reg;
    logic [lrip_pkg::OUT_DATA_W-1:0] out_word_next;

    logic [COL_W-1:0]  cspan;
    logic [ROW_W-1:0]  rspan;
    logic [17:0]       n_val;
    logic              npos;
    logic              drop;
    logic              oob;
    logic [16:0]       frac;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic              wr_proj;
    logic              rd_en;
    logic              clr_pix;
    logic              vwr_en;
    logic [ADDR_W-1:0] vwr_addr;
    logic              vwr_data;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= lrip_pkg::RST_RANGE_LIMIT;
            fov_down_reg    <= lrip_pkg::RST_FOV_DOWN;
            fov_scale_reg   <= lrip_pkg::RST_FOV_SCALE;
            image_rows_reg  <= lrip_pkg::RST_IMAGE_ROWS;
            image_cols_reg  <= lrip_pkg::RST_IMAGE_COLS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lrip_pkg::REG_RANGE_LIMIT: range_limit_reg <= cfg_data[15:0];
                lrip_pkg::REG_FOV_DOWN:    fov_down_reg    <= cfg_data[14:0];
                lrip_pkg::REG_FOV_SCALE:   fov_scale_reg   <= cfg_data;
                lrip_pkg::REG_IMAGE_ROWS:  image_rows_reg  <= cfg_data[6:0];
                lrip_pkg::REG_IMAGE_COLS:  image_cols_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Clamp image sizes and take the span (size minus one)
    always_comb
    begin
        if (32'(image_cols_reg) > 32'(MAX_COLS))
        begin
            cspan = COL_W'(MAX_COLS - 1);
        end
        else if (image_cols_reg == '0)
        begin
            cspan = '0;
        end
        else
        begin
            cspan = COL_W'(image_cols_reg - 11'd1);
        end
        if (32'(image_rows_reg) > 32'(MAX_ROWS))
        begin
            rspan = ROW_W'(MAX_ROWS - 1);
        end
        else if (image_rows_reg == '0)
        begin
            rspan = '0;
        end
        else
        begin
            rspan = ROW_W'(image_rows_reg - 7'd1);
        end
    end

    // Angle offset from the lower field-of-view limit, and drop checks
    assign n_val = 18'(16384) + 18'(fov_down_reg) - 18'(polar_reg);
    assign npos  = !n_val[17] && (n_val != '0);
    assign drop  = (rho_reg > range_limit_reg) || (32'(pnum_reg) >= 32'(MAX_POINTS));
    assign oob   = (32'(rrow_reg) >= 32'(MAX_ROWS)) || (32'(rcol_reg) >= 32'(MAX_COLS));

    // Row fraction in Q16, clamped to [0, 1]
    always_comb
    begin
        if (!npos_reg)
        begin
            frac = 17'h10000;
        end
        else if (nprod_reg[47:32] != '0)
        begin
            frac = '0;
        end
        else
        begin
            frac = 17'h10000 - 17'(nprod_reg[31:16]);
        end
    end

    assign row_sel = op_reg ? ROW_W'(rrow_reg) : row_prod_reg[ROW_W+15:16];
    assign col_sel = op_reg ? COL_W'(rcol_reg) : col_calc_reg;

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            op_reg    <= in_op;
            rho_reg   <= in_data[15:0];
            az_reg    <= in_data[31:16];
            polar_reg <= in_data[47:32];
            pnum_reg  <= in_data[64:48];
            rrow_reg  <= in_data[70:65];
            rcol_reg  <= in_data[80:71];
            clr_reg   <= in_data[81];
        end
        if (cmd.mul1)
        begin
            col_prod_reg <= (COL_W+16)'(az_reg ^ 16'h8000) * (COL_W+16)'(cspan);
            nprod_reg    <= 48'(n_val[15:0]) * 48'(fov_scale_reg);
            npos_reg     <= npos;
            skip_reg     <= op_reg ? oob : drop;
        end
        if (cmd.mul2)
        begin
            row_prod_reg <= (ROW_W+17)'(frac) * (ROW_W+17)'(rspan);
            col_calc_reg <= col_prod_reg[COL_W+15:16];
        end
        if (cmd.addr)
        begin
            row_reg  <= row_sel;
            col_reg  <= col_sel;
            addr_reg <= ADDR_W'(row_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(col_sel);
        end
    end

    // Advance the reset sweep over the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
        end
    end

    // Report status to the controller
    always_comb
    begin
        stat.sweep_last = (32'(sweep_cnt_reg) == PIXELS - 1);
        stat.is_read    = op_reg;
    end

    // Store access control
    assign wr_proj = cmd.mem && !op_reg && !skip_reg;
    assign rd_en   = cmd.mem && op_reg && !skip_reg;
    assign clr_pix = cmd.clear_wr && clr_reg && rd_valid_reg && !skip_reg;

    always_comb
    begin
        vwr_en   = cmd.sweep || wr_proj || clr_pix;
        vwr_addr = cmd.sweep ? sweep_cnt_reg : addr_reg;
        vwr_data = wr_proj;
    end

    // Pixel stores: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_proj)
        begin
            range_mem[addr_reg] <= rho_reg;
            index_mem[addr_reg] <= pnum_reg;
        end
        if (rd_en)
        begin
            rd_range_reg <= range_mem[addr_reg];
            rd_index_reg <= index_mem[addr_reg];
        end
    end

    // Valid marks
    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            valid_mem[vwr_addr] <= vwr_data;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[addr_reg];
        end
    end

    // Build the result word
    always_comb
    begin
        out_word_next = '0;
        if (op_reg)
        begin
            if (!skip_reg && rd_valid_reg)
            begin
                out_word_next[32:17] = rd_range_reg;
                out_word_next[49:33] = rd_index_reg;
                out_word_next[50]    = 1'b1;
            end
        end
        else if (!skip_reg)
        begin
            out_word_next[0]    = 1'b1;
            out_word_next[6:1]  = 6'(row_reg);
            out_word_next[16:7] = 10'(col_reg);
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_data = out_word_reg;

endmodule

// ===== rtl/core/lidar_range_image_projector.sv =====
// Words are taken one at a time: the sequencer steps each word through two multiply
// phases, the address phase and the single store port, plus a read-modify-write
// phase for reads, and takes the next word only once the result is loaded, which
// waits while an earlier result is still not taken.
// Reset: registers take their reset values; then a sweep over all MAX_ROWS*MAX_COLS
// entries (65536 by default) clears the valid marks with s_axis_tready low.
// ============================================================================
// lidar_range_image_projector - spherical range image projector
// Maps lidar points to range image pixels and serves pixel read requests.
// ============================================================================
module lidar_range_image_projector
#(
    parameter int MAX_ROWS   = lrip_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = lrip_pkg::DEF_MAX_COLS,
    parameter int MAX_POINTS = lrip_pkg::DEF_MAX_POINTS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrip_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    // input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // rho[15:0], azimuth[31:16], polar_angle[47:32], point_number[64:48],
    // read_row[70:65], read_col[80:71], clear_after[81], zero[87:82]
    input  logic [lrip_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  logic                            s_axis_tuser,
    // result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // stored[0], row[6:1], col[16:7], pixel_range[32:17],
    // pixel_point[49:33], pixel_valid[50], zero[55:51]
    output logic [lrip_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    lrip_pkg::lrip_cmd_t  cmd;
    lrip_pkg::lrip_stat_t stat;

    // Configuration writes are taken at any time
    assign cfg_ready = 1'b1;

    lrip_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lrip_dpath
    #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_POINTS (MAX_POINTS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== tb/lidar_range_image_projector_tb.sv =====
// ============================================================================
// lidar_range_image_projector_tb - self-checking bench for the range image projector
// Drives project and read words into the block, predicts every result word
// from a private copy of the pixel stores and registers, and compares each
// result field by field. Runs directed corner words first, then random
// phases under changing register settings and handshake idling.
// ============================================================================
module lidar_range_image_projector_tb;

    localparam int PIXELS          = lrip_pkg::DEF_MAX_ROWS * lrip_pkg::DEF_MAX_COLS;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 20;

    // Indexes with no register behind them
    localparam logic [lrip_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [lrip_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic               op;
        logic [15:0]        rho;
        logic signed [15:0] azimuth;
        logic [15:0]        polar_angle;
        logic [16:0]        point_number;
        logic [5:0]         read_row;
        logic [9:0]         read_col;
        logic               clear_after;
    } pixel_request_t;

    typedef struct packed {
        logic        stored;
        logic [5:0]  row;
        logic [9:0]  col;
        logic [15:0] pixel_range;
        logic [16:0] pixel_point;
        logic        pixel_valid;
    } pixel_result_t;

    localparam int REQ_W = $bits(pixel_request_t);

    // Mirror of the pixel stores and registers, plus the queue of awaited results
    class range_image_board;
        logic [15:0]   range_limit;
        logic [14:0]   fov_down_mag;
        logic [31:0]   fov_scale;
        logic [6:0]    image_rows;
        logic [10:0]   image_cols;
        bit [15:0]     range_store [PIXELS];
        bit [16:0]     index_store [PIXELS];
        bit            valid_map [PIXELS];
        bit            ever_written [PIXELS];
        int            written_pixels [$];
        int            last_pixel;
        pixel_result_t awaited_results [$];
        int            errors;

        function new();
            range_limit  = lrip_pkg::RST_RANGE_LIMIT;
            fov_down_mag = lrip_pkg::RST_FOV_DOWN;
            fov_scale    = lrip_pkg::RST_FOV_SCALE;
            image_rows   = lrip_pkg::RST_IMAGE_ROWS;
            image_cols   = lrip_pkg::RST_IMAGE_COLS;
            last_pixel   = 0;
            errors       = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Register write; unknown indexes are ignored, values truncate to width
        function void write_register(logic [lrip_pkg::CFG_IDX_W-1:0] idx,
                                     logic [31:0] value);
            case (idx)
                lrip_pkg::REG_RANGE_LIMIT: range_limit  = value[15:0];
                lrip_pkg::REG_FOV_DOWN:    fov_down_mag = value[14:0];
                lrip_pkg::REG_FOV_SCALE:   fov_scale    = value;
                lrip_pkg::REG_IMAGE_ROWS:  image_rows   = value[6:0];
                lrip_pkg::REG_IMAGE_COLS:  image_cols   = value[10:0];
                default: ;
            endcase
        endfunction

        // Clamp a size register into [1, limit] and return size - 1
        function longint unsigned usable_span(int unsigned size, int unsigned limit);
            int unsigned v;
            v = (size > limit) ? limit : size;
            if (v < 1) v = 1;
            return v - 1;
        endfunction

        // Work out the result of an accepted word and update the stores
        function void take_request(pixel_request_t req);
            pixel_result_t   res;
            longint unsigned az_u, cspan, rspan, col, row, nu, scale, q, frac;
            longint          n;
            int              addr;
            res = '0;
            if (req.op == lrip_pkg::OP_PROJECT)
            begin
                if (req.rho <= range_limit &&
                    int'(req.point_number) < lrip_pkg::DEF_MAX_POINTS)
                begin
                    cspan = usable_span(image_cols, lrip_pkg::DEF_MAX_COLS);
                    rspan = usable_span(image_rows, lrip_pkg::DEF_MAX_ROWS);
                    az_u  = req.azimuth ^ 16'h8000;
                    col   = (az_u * cspan) >> 16;
                    n = 16384;
                    n = n + fov_down_mag;
                    n = n - req.polar_angle;
                    if (n <= 0)
                    begin
                        frac = 65536;
                    end
                    else
                    begin
                        nu    = n;
                        scale = fov_scale;
                        q     = (nu * scale) >> 16;
                        frac  = (q >= 65536) ? 0 : 65536 - q;
                    end
                    row  = (frac * rspan) >> 16;
                    addr = int'(row) * lrip_pkg::DEF_MAX_COLS + int'(col);
                    range_store[addr] = req.rho;
                    index_store[addr] = req.point_number;
                    valid_map[addr]   = 1'b1;
                    if (!ever_written[addr])
                    begin
                        ever_written[addr] = 1'b1;
                        written_pixels.push_back(addr);
                    end
                    last_pixel = addr;
                    res.stored = 1'b1;
                    res.row    = row[5:0];
                    res.col    = col[9:0];
                end
            end
            else if (int'(req.read_row) < lrip_pkg::DEF_MAX_ROWS &&
                     int'(req.read_col) < lrip_pkg::DEF_MAX_COLS)
            begin
                addr = int'(req.read_row) * lrip_pkg::DEF_MAX_COLS + int'(req.read_col);
                if (valid_map[addr])
                begin
                    res.pixel_range = range_store[addr];
                    res.pixel_point = index_store[addr];
                    res.pixel_valid = 1'b1;
                    if (req.clear_after) valid_map[addr] = 1'b0;
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one accepted result word against the oldest awaited result
        function void match_result(logic [lrip_pkg::OUT_DATA_W-1:0] word);
            pixel_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result word with nothing awaited, expected none, actual %h",
                         $time, word);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("stored",      want.stored,      word[0]);
            compare_field("row",         want.row,         word[6:1]);
            compare_field("col",         want.col,         word[16:7]);
            compare_field("pixel_range", want.pixel_range, word[32:17]);
            compare_field("pixel_point", want.pixel_point, word[49:33]);
            compare_field("pixel_valid", want.pixel_valid, word[50]);
        endfunction
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [lrip_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [31:0]                     cfg_data      = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lrip_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lrip_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    range_image_board board = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_requests  = 0;

    lidar_range_image_projector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Register write; leaves cfg_valid high so writes can go back to back
    task automatic write_reg(input logic [lrip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        board.write_register(idx, value);
    endtask

    // Write all five registers, with junk above each register's width
    task automatic apply_settings(input logic [15:0] limit, input logic [14:0] fdown,
                                  input logic [31:0] scale, input logic [6:0] rows,
                                  input logic [10:0] cols);
        write_reg(lrip_pkg::REG_RANGE_LIMIT, {16'($urandom), limit});
        write_reg(lrip_pkg::REG_FOV_DOWN,    {17'($urandom), fdown});
        write_reg(lrip_pkg::REG_FOV_SCALE,   scale);
        write_reg(lrip_pkg::REG_IMAGE_ROWS,  {25'($urandom), rows});
        write_reg(lrip_pkg::REG_IMAGE_COLS,  {21'($urandom), cols});
        cfg_valid <= 1'b0;
    endtask

    function automatic pixel_request_t noise_request();
        pixel_request_t req;
        req = REQ_W'({$urandom, $urandom, $urandom});
        return req;
    endfunction

    // Offer one input word, with random idle cycles ahead of it
    task automatic send_request(input pixel_request_t req);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {6'b0, req.clear_after, req.read_col, req.read_row,
                          req.point_number, req.polar_angle, req.azimuth, req.rho};
        s_axis_tuser  <= req.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.take_request(req);
    endtask

    task automatic send_point(input logic [15:0] rho, input logic [15:0] az,
                              input logic [15:0] polar, input logic [16:0] pnum);
        pixel_request_t req;
        req              = noise_request();
        req.op           = lrip_pkg::OP_PROJECT;
        req.rho          = rho;
        req.azimuth      = az;
        req.polar_angle  = polar;
        req.point_number = pnum;
        send_request(req);
    endtask

    task automatic send_read(input int pixel, input logic clear);
        pixel_request_t req;
        req             = noise_request();
        req.op          = lrip_pkg::OP_READ;
        req.read_row    = 6'(pixel / lrip_pkg::DEF_MAX_COLS);
        req.read_col    = 10'(pixel % lrip_pkg::DEF_MAX_COLS);
        req.clear_after = clear;
        send_request(req);
    endtask

    // Drop valid, let every awaited result arrive, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: check accepted words, stall at random, hold off on request
    initial
    begin : result_sink
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) board.match_result(m_axis_tdata);
            if (served != hold_off_requests)
            begin
                served    = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        pixel_request_t  req;
        int              pick;
        longint          fov_est, top, lo, hi;
        logic [15:0]     limit;
        logic [14:0]     fdown;
        logic [31:0]     scale;
        logic [6:0]      rows;
        logic [10:0]     cols;
        int unsigned     span_total;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Corner words under the reset settings
        send_point(16'd0,     16'h8000, 16'd0,     17'd0);
        send_point(16'hFFFF,  16'h7FFF, 16'd32768, 17'h1FFFF);
        send_point(16'd12345, 16'h0000, 16'd20935, 17'd77);
        // Overwrite the same pixel
        send_point(16'd222,   16'h0000, 16'd20935, 17'd88);
        send_point(16'd500,   16'd1234, 16'd16384, 17'd5);
        send_read(0, 1'b0);
        send_read(63 * lrip_pkg::DEF_MAX_COLS + 1022, 1'b1);
        // Pixel now cleared, read shows no point
        send_read(63 * lrip_pkg::DEF_MAX_COLS + 1022, 1'b0);
        send_read(63 * lrip_pkg::DEF_MAX_COLS + 511, 1'b0);
        send_read(board.last_pixel, 1'b1);
        send_point(16'd7,     16'h7FFF, 16'd32768, 17'h10000);
        send_read(board.last_pixel, 1'b1);
        send_read(board.last_pixel, 1'b1);
        wait_idle();

        // Range limit at 1000, zero scale, sizes out of range, unknown indexes
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        apply_settings(16'd1000, 15'd0, 32'd0, 7'd0, 11'd2047);
        send_point(16'd1000, 16'($urandom), 16'($urandom_range(32768)), 17'($urandom));
        send_read(board.last_pixel, 1'b0);
        send_point(16'd1001, 16'($urandom), 16'($urandom_range(32768)), 17'($urandom));
        send_point(16'hFFFF, 16'($urandom), 16'($urandom_range(32768)), 17'($urandom));
        wait_idle();

        // Tiny scale, one column, rows above the limit
        apply_settings(16'hFFFF, 15'd16384, 32'd1, 7'd127, 11'd1);
        send_point(16'd4000, 16'($urandom), 16'd0,     17'($urandom));
        send_point(16'd4001, 16'($urandom), 16'd32768, 17'($urandom));
        send_read(board.last_pixel, 1'b0);
        wait_idle();

        // Largest scale, one row, zero columns
        apply_settings(16'hFFFF, 15'd16384, 32'hFFFF_FFFF, 7'd1, 11'd0);
        send_point(16'd9, 16'($urandom), 16'd32767, 17'($urandom));
        send_read(board.last_pixel, 1'b1);
        send_read(board.last_pixel, 1'b0);
        wait_idle();

        // Random phases
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    limit = lrip_pkg::RST_RANGE_LIMIT;
                    fdown = lrip_pkg::RST_FOV_DOWN;
                    scale = lrip_pkg::RST_FOV_SCALE;
                    rows  = lrip_pkg::RST_IMAGE_ROWS;
                    cols  = lrip_pkg::RST_IMAGE_COLS;
                end
                1:
                begin
                    limit = 16'hFFFF; fdown = 15'd16384; scale = 32'hFFFF_FFFF;
                    rows = 7'd64; cols = 11'd1024;
                end
                2:
                begin
                    limit = 16'($urandom_range(30000, 65535)); fdown = 15'd0; scale = 32'd1;
                    rows = 7'd2; cols = 11'd2;
                end
                default:
                begin
                    limit = ($urandom_range(3) == 0) ? 16'($urandom_range(20000, 65535))
                                                     : 16'hFFFF;
                    fdown = 15'($urandom_range(16384));
                    span_total = $urandom_range(512, 32768);
                    scale = 32'((64'h1_0000_0000 + span_total / 2) / span_total);
                    rows  = 7'($urandom_range(2, 64));
                    cols  = 11'($urandom_range(2, 1024));
                end
            endcase
            apply_settings(limit, fdown, scale, rows, cols);

            // Band of polar angles that lands inside the field of view
            fov_est = (board.fov_scale == 0) ? 32768 : 64'h1_0000_0000 / board.fov_scale;
            if (fov_est > 32768) fov_est = 32768;
            top = 16384 + board.fov_down_mag;
            lo  = top - fov_est - 256;
            hi  = top + 256;
            if (lo < 0) lo = 0;
            if (hi > 32768) hi = 32768;

            case (phase % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
                default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
            endcase
            // Hold the result side off while words keep coming, so the block backs up
            if (phase == PRESSURE_PHASE) hold_off_requests++;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                req = noise_request();
                if (board.written_pixels.size() > 0 && $urandom_range(99) < 35)
                begin
                    pick = board.written_pixels[$urandom_range(board.written_pixels.size() - 1)];
                    req.op          = lrip_pkg::OP_READ;
                    req.read_row    = 6'(pick / lrip_pkg::DEF_MAX_COLS);
                    req.read_col    = 10'(pick % lrip_pkg::DEF_MAX_COLS);
                    req.clear_after = ($urandom_range(99) < 40);
                end
                else
                begin
                    req.op = lrip_pkg::OP_PROJECT;
                    case ($urandom_range(9))
                        0: req.rho = 16'd0;
                        1: req.rho = 16'hFFFF;
                        2: req.rho = (board.range_limit == 16'hFFFF) ? 16'hFFFF :
                                     16'($urandom_range(int'(board.range_limit) + 1, 65535));
                        default: req.rho = 16'($urandom_range(int'(board.range_limit)));
                    endcase
                    if ($urandom_range(99) < 80)
                        req.polar_angle = 16'($urandom_range(int'(lo), int'(hi)));
                    else
                        req.polar_angle = 16'($urandom_range(32768));
                end
                send_request(req);
            end
            wait_idle();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lrip_pkg.sv
rtl/core/lrip_ctrl.sv
rtl/core/lrip_dpath.sv
rtl/core/lidar_range_image_projector.sv
tb/lidar_range_image_projector_tb.sv
